FILE: rtl/sht_pkg.sv
// Shared constants, codes and types for the service handle slot table.
// Used by sht_ram, sht_engine and service_handle_slot_table; depends on nothing.
`timescale 1ns / 1ps

package sht_pkg;

    localparam int SLOTS        = 256;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int HANDLE_BITS  = 24;
    localparam int CONTEXT_BITS = 16;
    localparam int HARBOR_BITS  = 8;
    localparam int HARBOR_SHIFT = 24;
    localparam int FULL_W       = 32;

    localparam logic [HANDLE_BITS-1:0] HANDLE_MAX = {HANDLE_BITS{1'b1}};

    localparam logic [1:0] MODE_REGISTER = 2'd0;
    localparam logic [1:0] MODE_RETIRE   = 2'd1;
    localparam logic [1:0] MODE_LOOKUP   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [FULL_W-1:0]       handle;
        logic [CONTEXT_BITS-1:0] ctx;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_entry            wdata;
        logic [SLOT_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [1:0]              status;
        logic [FULL_W-1:0]       handle;
        logic [CONTEXT_BITS-1:0] ctx;
    } t_result;

    // Next candidate handle: past the mask it wraps to 1, since 0 is reserved.
    function automatic logic [HANDLE_BITS-1:0] wrap_next(input logic [HANDLE_BITS-1:0] h);
        return (h == HANDLE_MAX) ? HANDLE_BITS'(1) : h + HANDLE_BITS'(1);
    endfunction

endpackage

FILE: rtl/service_handle_slot_table.sv
// Handle table, one word in flight. A retire or lookup passes from acceptance through a
// slot check to its result; an unused mode goes straight to its result. A register
// request first probes n slots, where n (1..SLOTS) is the number of slots probed, one
// occupancy bit per cycle. A result waiting in the output register stalls the input.
// Reset (i_rst_n low, synchronous) frees every slot, sets the next handle to 1 and the
// harbor id to 0; no clearing pass is needed.
`timescale 1ns / 1ps

module service_handle_slot_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,   // harbor_id
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // handle_in [31:0], context_in [47:32]
    input  logic [1:0]  s_axis_tuser,  // mode [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // handle_out [31:0], context_out [47:32]
    output logic [1:0]  m_axis_tuser   // status [1:0]
);

    logic [sht_pkg::HARBOR_BITS-1:0] r_harbor;
    logic                            r_out_valid;
    sht_pkg::t_result                r_out;

    sht_pkg::t_ram_req               ram_req;
    sht_pkg::t_entry                 ram_rdata;
    sht_pkg::t_result                res;
    logic                            res_valid;
    logic                            res_ready;

    // The output register takes a new word when empty or when its word leaves.
    assign res_ready = !r_out_valid || m_axis_tready;

    sht_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tuser),
        .i_handle    (s_axis_tdata[31:0]),
        .i_ctx       (s_axis_tdata[47:32]),
        .i_harbor    (r_harbor),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    sht_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_harbor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_harbor <= i_cfg_wdata;
            end
            if (res_ready) begin
                r_out_valid <= res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.ctx, r_out.handle};
    assign m_axis_tuser  = r_out.status;

endmodule

FILE: rtl/sht_ram.sv
// Slot store: stored full handle and context per slot, one write and one read port.
// Read data is registered. Depends on sht_pkg.
`timescale 1ns / 1ps

module sht_ram (
    input  logic              i_clk,
    input  sht_pkg::t_ram_req i_req,
    output sht_pkg::t_entry   o_rdata
);

    sht_pkg::t_entry r_mem [sht_pkg::SLOTS];
    sht_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sht_engine.sv
// Request sequencer: slot occupancy bits, next-handle counter, probe and check logic.
// Drives the slot store through a t_ram_req struct. Depends on sht_pkg.
`timescale 1ns / 1ps

module sht_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_mode,
    input  logic [sht_pkg::FULL_W-1:0]           i_handle,
    input  logic [sht_pkg::CONTEXT_BITS-1:0]     i_ctx,
    input  logic [sht_pkg::HARBOR_BITS-1:0]      i_harbor,
    output logic                                 o_res_valid,
    input  logic                                 i_res_ready,
    output sht_pkg::t_result                     o_res,
    output sht_pkg::t_ram_req                    o_ram_req,
    input  sht_pkg::t_entry                      i_ram_rdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CHECK = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic [sht_pkg::SLOTS-1:0]           r_valid, n_valid;
    logic [sht_pkg::HANDLE_BITS-1:0]     r_next, n_next;
    logic [sht_pkg::HANDLE_BITS-1:0]     r_h, n_h;
    logic [sht_pkg::SLOT_W-1:0]          r_cnt, n_cnt;
    logic [1:0]                          r_mode, n_mode;
    logic [sht_pkg::FULL_W-1:0]          r_hin, n_hin;
    logic [sht_pkg::CONTEXT_BITS-1:0]    r_ctx, n_ctx;
    sht_pkg::t_result                    r_res, n_res;

    logic                                accept;
    logic [sht_pkg::SLOT_W-1:0]          probe_slot;
    logic [sht_pkg::SLOT_W-1:0]          check_slot;
    logic [sht_pkg::FULL_W-1:0]          full_handle;

    assign accept      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    assign probe_slot  = r_h[sht_pkg::SLOT_W-1:0];
    assign check_slot  = r_hin[sht_pkg::SLOT_W-1:0];
    assign full_handle = (sht_pkg::FULL_W'(i_harbor) << sht_pkg::HARBOR_SHIFT)
                       | sht_pkg::FULL_W'(r_h);

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_next  = r_next;
        n_h     = r_h;
        n_cnt   = r_cnt;
        n_mode  = r_mode;
        n_hin   = r_hin;
        n_ctx   = r_ctx;
        n_res   = r_res;

        o_ram_req.we           = 1'b0;
        o_ram_req.waddr        = probe_slot;
        o_ram_req.wdata.handle = full_handle;
        o_ram_req.wdata.ctx    = r_ctx;
        // The slot of an incoming word is read straight away so that it is
        // ready for the comparison in the following cycle.
        o_ram_req.raddr        = i_handle[sht_pkg::SLOT_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_mode = i_mode;
                    n_hin  = i_handle;
                    n_ctx  = i_ctx;
                    n_h    = r_next;
                    n_cnt  = '0;
                    case (i_mode)
                        sht_pkg::MODE_REGISTER: n_state = ST_PROBE;
                        sht_pkg::MODE_RETIRE,
                        sht_pkg::MODE_LOOKUP:   n_state = ST_CHECK;
                        default: begin
                            n_res.status = sht_pkg::STATUS_NOT_FOUND;
                            n_res.handle = '0;
                            n_res.ctx    = '0;
                            n_state      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (!r_valid[probe_slot]) begin
                    o_ram_req.we        = 1'b1;
                    n_valid[probe_slot] = 1'b1;
                    n_next              = sht_pkg::wrap_next(r_h);
                    n_res.status        = sht_pkg::STATUS_OK;
                    n_res.handle        = full_handle;
                    n_res.ctx           = '0;
                    n_state             = ST_DONE;
                end else if (r_cnt == sht_pkg::SLOT_W'(sht_pkg::SLOTS - 1)) begin
                    n_res.status = sht_pkg::STATUS_FULL;
                    n_res.handle = '0;
                    n_res.ctx    = '0;
                    n_state      = ST_DONE;
                end else begin
                    n_h   = sht_pkg::wrap_next(r_h);
                    n_cnt = r_cnt + sht_pkg::SLOT_W'(1);
                end
            end
            ST_CHECK: begin
                n_res.handle = '0;
                if (r_valid[check_slot] && (i_ram_rdata.handle == r_hin)) begin
                    n_res.status = sht_pkg::STATUS_OK;
                    n_res.ctx    = i_ram_rdata.ctx;
                    if (r_mode == sht_pkg::MODE_RETIRE) begin
                        n_valid[check_slot] = 1'b0;
                    end
                end else begin
                    n_res.status = sht_pkg::STATUS_NOT_FOUND;
                    n_res.ctx    = '0;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_next  <= sht_pkg::HANDLE_BITS'(1);
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_next  <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h    <= n_h;
        r_cnt  <= n_cnt;
        r_mode <= n_mode;
        r_hin  <= n_hin;
        r_ctx  <= n_ctx;
        r_res  <= n_res;
    end

`ifndef SYNTHESIS
    // Handle 0 is reserved, so the running counter never holds it.
    a_next_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next != '0)
        else $error("next handle counter holds the reserved value");

    // A comparison only ever follows an accepted retire or lookup word.
    a_check_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> ($past(r_state) == ST_IDLE))
        else $error("slot comparison entered without a fresh request");

    // Claiming a free slot marks it occupied in the following cycle.
    a_claim_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PROBE && !r_valid[probe_slot]) |=> r_valid[$past(probe_slot)])
        else $error("claimed slot not marked occupied");

    // A register request starts its probe with a cleared candidate count.
    a_probe_starts_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == sht_pkg::MODE_REGISTER) |=> (r_cnt == '0 && r_state == ST_PROBE))
        else $error("probe did not start from the first candidate");
`endif

endmodule
